>>> rtl/name_hash_table_probe_top_macros.svh
// Assertion macros of the name hash table, used by the probe sequencer.
// Expects signal clk in the scope of every use, and arst_n as well for NHTP_ASSERT.
`ifndef NAME_HASH_TABLE_PROBE_TOP_MACROS_SVH
`define NAME_HASH_TABLE_PROBE_TOP_MACROS_SVH

// Checked on every edge outside reset.
`define NHTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define NHTP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/nhtp_pkg.sv
// Shared widths, defaults, status codes and control types of the name hash table.
// No dependencies.
`timescale 1ns / 1ps

package nhtp_pkg;

	localparam int unsigned TABLE_SIZE_DEF = 16;
	localparam int unsigned NAME_LEN_DEF   = 16;

	localparam int unsigned CHAR_W   = 7;
	localparam int unsigned CHAR_NUM = 2 ** CHAR_W;
	localparam int unsigned HANDLE_W = 16;
	localparam int unsigned STEP_W   = 4;
	localparam int unsigned STEP_NUM = 2 ** STEP_W;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned CNT_W    = 7;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Probe sequencer to character accumulator.
	typedef struct packed {
		logic take;
		logic clear;
	} acc_ctl_t;

endpackage

>>> rtl/nhtp_if.sv
// Request and response channel interfaces of the name hash table.
// Depends on nhtp_pkg.
`timescale 1ns / 1ps

interface nhtp_req_if
	import nhtp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                mode;
	logic [CHAR_W-1:0]   character;
	logic                last;
	logic [HANDLE_W-1:0] handle;

	modport source (output valid, output mode, output character, output last,
		output handle, input ready);
	modport sink (input valid, input mode, input character, input last,
		input handle, output ready);
endinterface

interface nhtp_rsp_if
	import nhtp_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [HANDLE_W-1:0] found_handle;

	modport source (output valid, output status, output slot, output found_handle,
		input ready);
	modport sink (input valid, input status, input slot, input found_handle,
		output ready);
endinterface

>>> rtl/nhtp_accum.sv
// Character accumulator: running hash, character count and key buffer.
// Depends on nhtp_pkg.
`timescale 1ns / 1ps

module nhtp_accum
	import nhtp_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int unsigned NAME_LEN   = NAME_LEN_DEF,
	localparam int unsigned HASH_W    = $clog2(TABLE_SIZE),
	localparam int unsigned IDX_W     = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  acc_ctl_t                     ctl,
	input  logic [CHAR_W-1:0]            character,
	output logic [HASH_W-1:0]            hash_next,
	output logic [NAME_LEN*CHAR_W-1:0]   key
);

	typedef logic [HASH_W-1:0] mod_tbl_t [0:CHAR_NUM-1];

	function automatic mod_tbl_t build_char_mod();
		mod_tbl_t t;
		for (int i = 0; i < CHAR_NUM; i++) t[i] = HASH_W'(i % TABLE_SIZE);
		return t;
	endfunction

	localparam mod_tbl_t CHAR_MOD = build_char_mod();

	logic [HASH_W-1:0] hash_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CHAR_W-1:0] key_buf_q [NAME_LEN];
	logic [HASH_W:0]   sum;
	logic              has_char;

	assign has_char = (character != '0);

	always_comb begin
		sum = {1'b0, hash_q} + {1'b0, CHAR_MOD[character]};
		if (!has_char) begin
			hash_next = hash_q;
		end else if (sum >= (HASH_W+1)'(TABLE_SIZE)) begin
			hash_next = HASH_W'(sum - (HASH_W+1)'(TABLE_SIZE));
		end else begin
			hash_next = sum[HASH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			cnt_q  <= '0;
			for (int i = 0; i < NAME_LEN; i++) key_buf_q[i] <= '0;
		end else if (ctl.clear) begin
			hash_q <= '0;
			cnt_q  <= '0;
			for (int i = 0; i < NAME_LEN; i++) key_buf_q[i] <= '0;
		end else if (ctl.take && has_char) begin
			hash_q <= hash_next;
			// keep only the first characters; the count saturates
			if (cnt_q < CNT_W'(NAME_LEN)) key_buf_q[cnt_q[IDX_W-1:0]] <= character;
			if (cnt_q != CNT_MAX) cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	for (genvar g = 0; g < NAME_LEN; g++) begin : g_key
		assign key[g*CHAR_W +: CHAR_W] = key_buf_q[g];
	end

endmodule

>>> rtl/nhtp_table.sv
// Slot memories: handle memory with clearing pass after reset, and key memory.
// Depends on nhtp_pkg.
`timescale 1ns / 1ps

module nhtp_table
	import nhtp_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int unsigned NAME_LEN   = NAME_LEN_DEF,
	localparam int unsigned HASH_W    = $clog2(TABLE_SIZE),
	localparam int unsigned KEY_W     = NAME_LEN * CHAR_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [HASH_W-1:0]   rd_addr,
	input  logic                wr_en,
	input  logic [HASH_W-1:0]   wr_addr,
	input  logic [HANDLE_W-1:0] wr_handle,
	input  logic [KEY_W-1:0]    wr_key,
	output logic [HANDLE_W-1:0] rd_handle,
	output logic [KEY_W-1:0]    rd_key,
	output logic                busy
);

	localparam logic [HASH_W-1:0] CLR_LAST = HASH_W'(TABLE_SIZE - 1);

	logic [HANDLE_W-1:0] handle_mem [TABLE_SIZE];
	logic [KEY_W-1:0]    key_mem [TABLE_SIZE];
	logic                clearing_q;
	logic [HASH_W-1:0]   clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + HASH_W'(1);
			if (clr_q == CLR_LAST) clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			handle_mem[clr_q] <= '0;
		end else if (wr_en) begin
			handle_mem[wr_addr] <= wr_handle;
		end
		rd_handle <= handle_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en && !clearing_q) key_mem[wr_addr] <= wr_key;
		rd_key <= key_mem[rd_addr];
	end

	assign busy = clearing_q;

endmodule

>>> rtl/nhtp_probe.sv
// Probe sequencer: request handshake, slot probing and the result register.
// Depends on nhtp_pkg, nhtp_if and the assertion macros header.
`timescale 1ns / 1ps
`include "name_hash_table_probe_top_macros.svh"

module nhtp_probe
	import nhtp_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int unsigned NAME_LEN   = NAME_LEN_DEF,
	localparam int unsigned HASH_W    = $clog2(TABLE_SIZE),
	localparam int unsigned KEY_W     = NAME_LEN * CHAR_W
) (
	input  logic                clk,
	input  logic                arst_n,
	nhtp_req_if.sink            req,
	nhtp_rsp_if.source          rsp,
	input  logic [STEP_W-1:0]   step,
	input  logic [HASH_W-1:0]   hash_next,
	input  logic [KEY_W-1:0]    key,
	output acc_ctl_t            acc_ctl,
	input  logic                busy,
	output logic [HASH_W-1:0]   rd_addr,
	output logic                wr_en,
	output logic [HASH_W-1:0]   wr_addr,
	output logic [HANDLE_W-1:0] wr_handle,
	input  logic [HANDLE_W-1:0] rd_handle,
	input  logic [KEY_W-1:0]    rd_key
);

	typedef logic [HASH_W-1:0] step_tbl_t [0:STEP_NUM-1];

	function automatic step_tbl_t build_step_mod();
		step_tbl_t t;
		for (int i = 0; i < STEP_NUM; i++) t[i] = HASH_W'(i % TABLE_SIZE);
		return t;
	endfunction

	localparam step_tbl_t STEP_MOD = build_step_mod();
	localparam logic [HASH_W-1:0] PROBE_LAST = HASH_W'(TABLE_SIZE - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK
	} state_t;

	state_t              state_q;
	logic [HASH_W-1:0]   slot_q;
	logic [HASH_W-1:0]   n_q;
	logic                mode_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                out_valid_q;
	status_t             status_q;
	logic [SLOT_W-1:0]   slot_out_q;
	logic [HANDLE_W-1:0] found_q;

	logic              accept;
	logic              empty;
	logic              match;
	logic              finish;
	logic              out_free;
	logic              retire;
	logic [HASH_W:0]   step_sum;
	logic [HASH_W-1:0] slot_next;

	assign req.ready = (state_q == S_IDLE) && !busy;
	assign accept    = req.valid && req.ready;

	assign empty    = (rd_handle == '0);
	assign match    = !mode_q && (rd_key == key);
	assign finish   = empty || match || (n_q == PROBE_LAST);
	assign out_free = !out_valid_q || rsp.ready;
	assign retire   = (state_q == S_CHECK) && finish && out_free;

	always_comb begin
		step_sum = {1'b0, slot_q} + {1'b0, STEP_MOD[step]};
		if (step_sum >= (HASH_W+1)'(TABLE_SIZE)) begin
			slot_next = HASH_W'(step_sum - (HASH_W+1)'(TABLE_SIZE));
		end else begin
			slot_next = step_sum[HASH_W-1:0];
		end
	end

	assign acc_ctl.take  = accept;
	assign acc_ctl.clear = retire;

	assign rd_addr   = slot_q;
	assign wr_addr   = slot_q;
	assign wr_handle = handle_q;
	assign wr_en     = retire && empty && mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			slot_q      <= '0;
			n_q         <= '0;
			mode_q      <= 1'b0;
			handle_q    <= '0;
			status_q    <= ST_OK;
			slot_out_q  <= '0;
			found_q     <= '0;
		end else begin
			if (retire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && req.last) begin
						slot_q   <= hash_next;
						n_q      <= '0;
						mode_q   <= req.mode;
						handle_q <= req.handle;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (retire) begin
						state_q     <= S_IDLE;
						priority if (empty && mode_q) begin
							status_q   <= ST_OK;
							slot_out_q <= SLOT_W'(slot_q);
							found_q    <= '0;
						end else if (match && !empty) begin
							status_q   <= ST_OK;
							slot_out_q <= SLOT_W'(slot_q);
							found_q    <= rd_handle;
						end else begin
							status_q   <= mode_q ? ST_FULL : ST_MISS;
							slot_out_q <= '0;
							found_q    <= '0;
						end
					end else if (!finish) begin
						// collision: advance to the next slot
						slot_q  <= slot_next;
						n_q     <= n_q + HASH_W'(1);
						state_q <= S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.slot         = slot_out_q;
	assign rsp.found_handle = found_q;

	`NHTP_ASSERT(a_last_starts_probe, (req.valid && req.ready && req.last) |=> (state_q == S_READ), "final beat did not start a probe")
	`NHTP_ASSERT(a_result_from_check, (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_CHECK), "result loaded outside the compare step")
	`NHTP_ASSERT(a_write_empty_slot, wr_en |-> (rd_handle == '0 && mode_q && !busy), "table write to an occupied slot")
	`NHTP_ASSERT_ALWAYS(a_no_accept_in_probe, (state_q != S_IDLE) |-> !req.ready, "beat accepted during a probe")

endmodule

>>> rtl/name_hash_table_probe_top.sv
// Top level of the name hash table: configuration register, accumulator,
// slot memories and probe sequencer. Depends on nhtp_pkg, nhtp_if and all nhtp modules.
`timescale 1ns / 1ps

// A name enters one character per beat; a non-final beat leaves the channel open.
// The final beat starts a probe of the slot memories from the hash slot, and the
// request channel stays closed while 1 to TABLE_SIZE slots are visited: each probe
// is one registered read of the handle and key memories followed by one compare.
// The channel stays closed longer while the previous result still waits in the
// output register, since a probe retires only once that register is free.
// Characters of the next name can stream in while a result waits to be taken.
// After reset the handle memory is cleared one slot per cycle; the request channel
// opens once every slot is cleared, and configuration writes are taken throughout.
module name_hash_table_probe_top
	import nhtp_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int unsigned NAME_LEN   = NAME_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	nhtp_req_if.sink    req,
	nhtp_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned HASH_W = $clog2(TABLE_SIZE);
	localparam int unsigned KEY_W  = NAME_LEN * CHAR_W;
	localparam logic REG_PROBE_STEP = 1'b0;

	logic [STEP_W-1:0]   step_q;
	acc_ctl_t            acc_ctl;
	logic [HASH_W-1:0]   hash_next;
	logic [KEY_W-1:0]    key;
	logic                busy;
	logic [HASH_W-1:0]   rd_addr;
	logic                wr_en;
	logic [HASH_W-1:0]   wr_addr;
	logic [HANDLE_W-1:0] wr_handle;
	logic [HANDLE_W-1:0] rd_handle;
	logic [KEY_W-1:0]    rd_key;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PROBE_STEP) begin
			step_q <= pwdata[STEP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_PROBE_STEP) ? {{(32-STEP_W){1'b0}}, step_q} : '0;

	nhtp_accum #(
		.TABLE_SIZE(TABLE_SIZE),
		.NAME_LEN  (NAME_LEN)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (acc_ctl),
		.character(req.character),
		.hash_next(hash_next),
		.key      (key)
	);

	nhtp_table #(
		.TABLE_SIZE(TABLE_SIZE),
		.NAME_LEN  (NAME_LEN)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_handle(wr_handle),
		.wr_key   (key),
		.rd_handle(rd_handle),
		.rd_key   (rd_key),
		.busy     (busy)
	);

	nhtp_probe #(
		.TABLE_SIZE(TABLE_SIZE),
		.NAME_LEN  (NAME_LEN)
	) u_probe (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.step     (step_q),
		.hash_next(hash_next),
		.key      (key),
		.acc_ctl  (acc_ctl),
		.busy     (busy),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_handle(wr_handle),
		.rd_handle(rd_handle),
		.rd_key   (rd_key)
	);

endmodule

>>> test/name_hash_table_probe_top_tb.sv
// Self-checking testbench for name_hash_table_probe_top: streams names one character per beat,
// predicts each probe result from its own table copy, and checks results in order.
// Depends on nhtp_pkg, nhtp_if and the name_hash_table_probe_top RTL.
`timescale 1ns / 1ps

module name_hash_table_probe_top_tb;
	import nhtp_pkg::*;

	localparam int TBL          = TABLE_SIZE_DEF;
	localparam int KEY_LEN      = NAME_LEN_DEF;
	localparam int SETTLE       = 2 * TABLE_SIZE_DEF + 8;
	localparam int SEG_BEATS    = 105;
	localparam int POOL_DEPTH   = 32;
	localparam int POOL_NAME    = 24;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [2:0] ADDR_PROBE_STEP = 3'd0;

	typedef struct packed {
		logic                mode;
		logic [CHAR_W-1:0]   character;
		logic                last;
		logic [HANDLE_W-1:0] handle;
	} char_beat_t;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] found_handle;
	} probe_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	nhtp_req_if req_ch();
	nhtp_rsp_if rsp_ch();

	name_hash_table_probe_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predicted table and name accumulator
	logic [HANDLE_W-1:0]               tbl_handle [TBL];
	logic [KEY_LEN-1:0][CHAR_W-1:0]    tbl_key [TBL];
	logic [KEY_LEN-1:0][CHAR_W-1:0]    cur_key;
	logic [SLOT_W-1:0]                 cur_hash;
	logic [CNT_W-1:0]                  cur_count;
	logic [STEP_W-1:0]                 cur_step;

	char_beat_t    char_beats [$];
	probe_result_t probe_results [$];

	char_beat_t    drv_next;
	char_beat_t    drv_taken;
	probe_result_t rsp_want;

	int send_idle_pct;
	int recv_idle_pct;
	int errors;
	int beats_taken;
	int probes_checked;
	logic rsp_hold;
	logic hold_go;

	// scratch name and pool of inserted names, reused for lookup hits
	logic [CHAR_W-1:0] name_buf [200];
	int                name_len;
	logic [CHAR_W-1:0] pool_chars [POOL_DEPTH][POOL_NAME];
	int                pool_len [POOL_DEPTH];
	int                pool_size;

	function automatic void probe_name_table(input char_beat_t b);
		logic [SLOT_W-1:0] s;
		probe_result_t     r;
		bit                done;
		if (b.character != '0) begin
			cur_hash = cur_hash + SLOT_W'(b.character);
			if (cur_count < KEY_LEN)
				cur_key[cur_count] = b.character;
			if (cur_count != CNT_MAX)
				cur_count = cur_count + 1'b1;
		end
		if (!b.last)
			return;
		s = cur_hash;
		r.status = b.mode ? ST_FULL : ST_MISS;
		r.slot = '0;
		r.found_handle = '0;
		done = 1'b0;
		for (int n = 0; n < TBL && !done; n++) begin
			if (tbl_handle[s] == '0) begin
				if (b.mode) begin
					tbl_key[s] = cur_key;
					tbl_handle[s] = b.handle;
					r.status = ST_OK;
					r.slot = s;
				end
				done = 1'b1;
			end else if (!b.mode && tbl_key[s] == cur_key) begin
				r.status = ST_OK;
				r.slot = s;
				r.found_handle = tbl_handle[s];
				done = 1'b1;
			end else begin
				s = s + cur_step;
			end
		end
		cur_key = '0;
		cur_hash = '0;
		cur_count = '0;
		probe_results.push_back(r);
	endfunction

	// driver: hold the beat until taken, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.mode <= 1'b0;
			req_ch.character <= '0;
			req_ch.last <= 1'b0;
			req_ch.handle <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				drv_taken.mode = req_ch.mode;
				drv_taken.character = req_ch.character;
				drv_taken.last = req_ch.last;
				drv_taken.handle = req_ch.handle;
				probe_name_table(drv_taken);
				beats_taken++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (char_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_next = char_beats.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.mode <= drv_next.mode;
					req_ch.character <= drv_next.character;
					req_ch.last <= drv_next.last;
					req_ch.handle <= drv_next.handle;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				probes_checked++;
				if (probe_results.size() == 0) begin
					$error("unexpected result: status %0d slot %0d found_handle %h",
						rsp_ch.status, rsp_ch.slot, rsp_ch.found_handle);
					errors++;
				end else begin
					rsp_want = probe_results.pop_front();
					if (rsp_ch.status !== rsp_want.status) begin
						$error("status: expected %0d, got %0d", rsp_want.status, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.slot !== rsp_want.slot) begin
						$error("slot: expected %0d, got %0d", rsp_want.slot, rsp_ch.slot);
						errors++;
					end
					if (rsp_ch.found_handle !== rsp_want.found_handle) begin
						$error("found_handle: expected %h, got %h",
							rsp_want.found_handle, rsp_ch.found_handle);
						errors++;
					end
				end
			end
			rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// long receiver hold-off so the result register fills and the input stalls
	initial begin
		rsp_hold = 1'b0;
		wait (hold_go === 1'b1);
		@(negedge clk);
		rsp_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rsp_hold = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [CHAR_W-1:0] rand_char();
		return CHAR_W'($urandom_range(1, CHAR_NUM - 1));
	endfunction

	function automatic logic [HANDLE_W-1:0] rand_handle();
		int r;
		r = $urandom_range(9);
		if (r < 2)
			return '0;
		if (r == 2)
			return '1;
		return HANDLE_W'($urandom);
	endfunction

	function automatic void push_beat(input logic m, input logic [CHAR_W-1:0] c, input logic l,
		input logic [HANDLE_W-1:0] h);
		char_beat_t b;
		b.mode = m;
		b.character = c;
		b.last = l;
		b.handle = h;
		char_beats.push_back(b);
	endfunction

	// queue name_buf as one name; sprinkle zero characters, which add nothing
	function automatic void push_name(input logic ins, input logic [HANDLE_W-1:0] hdl);
		bit zero_tail;
		bit is_last;
		zero_tail = ($urandom_range(19) == 0);
		for (int i = 0; i < name_len; i++) begin
			if ($urandom_range(11) == 0)
				push_beat(1'($urandom_range(1)), '0, 1'b0, HANDLE_W'($urandom));
			is_last = !zero_tail && (i == name_len - 1);
			push_beat(is_last ? ins : 1'($urandom_range(1)), name_buf[i], is_last,
				is_last ? hdl : HANDLE_W'($urandom));
		end
		if (zero_tail)
			push_beat(ins, '0, 1'b1, hdl);
	endfunction

	function automatic void remember_name();
		int p;
		if (name_len > POOL_NAME)
			return;
		if (pool_size < POOL_DEPTH) begin
			p = pool_size;
			pool_size++;
		end else begin
			p = $urandom_range(POOL_DEPTH - 1);
		end
		pool_len[p] = name_len;
		for (int i = 0; i < name_len; i++)
			pool_chars[p][i] = name_buf[i];
	endfunction

	function automatic void gen_names(input int beats);
		int  goal;
		int  r;
		int  p;
		bit  ins;
		goal = char_beats.size() + beats;
		while (char_beats.size() < goal) begin
			r = $urandom_range(99);
			if (pool_size != 0 && r < 55) begin
				p = $urandom_range(pool_size - 1);
				name_len = pool_len[p];
				for (int i = 0; i < name_len; i++)
					name_buf[i] = pool_chars[p][i];
				r = $urandom_range(99);
				if (r < 15) begin
					// extra characters appended to the name; past the key length they move the hash only
					repeat ($urandom_range(1, 4)) begin
						name_buf[name_len] = rand_char();
						name_len++;
					end
				end else if (r < 25) begin
					name_buf[$urandom_range(name_len - 1)] = rand_char();
				end
			end else begin
				name_len = ($urandom_range(3) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
				for (int i = 0; i < name_len; i++)
					name_buf[i] = rand_char();
			end
			ins = ($urandom_range(3) == 0);
			push_name(ins, rand_handle());
			if (ins)
				remember_name();
		end
	endfunction

	task automatic write_step(input logic [STEP_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_PROBE_STEP;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_step = v;
	endtask

	// wait for every queued beat to go out and every result to come back
	task automatic drain();
		int n;
		n = 0;
		while (char_beats.size() != 0 || req_ch.valid)
			@(negedge clk);
		while (probe_results.size() != 0 && n < 5000) begin
			@(negedge clk);
			n++;
		end
		if (probe_results.size() != 0) begin
			$error("%0d predicted results never arrived", probe_results.size());
			errors++;
			probe_results.delete();
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		logic [STEP_W-1:0] mid_step;
		req_ch.valid = 1'b0;
		req_ch.mode = 1'b0;
		req_ch.character = '0;
		req_ch.last = 1'b0;
		req_ch.handle = '0;
		rsp_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_go = 1'b0;
		errors = 0;
		beats_taken = 0;
		probes_checked = 0;
		pool_size = 0;
		for (int i = 0; i < TBL; i++) begin
			tbl_handle[i] = '0;
			tbl_key[i] = '0;
		end
		cur_key = '0;
		cur_hash = '0;
		cur_count = '0;
		cur_step = STEP_RESET;
		send_idle_pct = 34;
		recv_idle_pct = 73;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty name: lookup misses, insert, then lookup hits at slot 0
		push_beat(1'b0, '0, 1'b1, 16'h1234);
		push_beat(1'b1, '0, 1'b1, '1);
		push_beat(1'b0, '0, 1'b1, '0);
		// top character value, then a zero-handle insert that leaves its slot empty
		push_beat(1'b1, '1, 1'b1, 16'h0001);
		push_beat(1'b1, '1, 1'b1, '0);
		push_beat(1'b0, '1, 1'b1, 16'hFFFF);
		push_beat(1'b0, 7'd1, 1'b1, 16'hABCD);
		// name as long as the key, with a zero character inside
		for (int i = 0; i < 17; i++)
			push_beat((i == 16) ? 1'b1 : 1'($urandom_range(1)),
				(i == 3) ? '0 : CHAR_W'(i * 37 + 5), i == 16, 16'h8000);
		drain();

		write_step('0);
		// overflow the character counter
		name_len = $urandom_range(130, 136);
		for (int i = 0; i < name_len; i++)
			name_buf[i] = rand_char();
		push_name(1'($urandom_range(1)), rand_handle());
		gen_names(SEG_BEATS);
		drain();

		send_idle_pct = 73;
		recv_idle_pct = 34;
		write_step(STEP_W'(8));
		gen_names(SEG_BEATS);
		drain();
		write_step('1);
		gen_names(SEG_BEATS);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		mid_step = STEP_W'($urandom_range(2, 7));
		write_step(mid_step);
		gen_names(SEG_BEATS);
		hold_go = 1'b1;
		drain();

		write_step(STEP_W'(1));
		gen_names(SEG_BEATS);
		drain();

		$display("Streamed %0d character beats and checked %0d probe results", beats_taken,
			probes_checked);
		$display("Probe steps 1, 0, 8, 15, %0d and 1, with sender and receiver idling, then a long hold-off",
			mid_step);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
